[rtl/bthome_pkg.sv]
// Shared types and codes for the BTHome service-data locator.
// Holds the beat structs of both channels and the verdict codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bthome_pkg;

  // Verdict given on the final byte of an advertisement.
  typedef enum logic [1:0] {
    STATUS_NONE        = 2'd0,
    STATUS_TOO_SHORT   = 2'd1,
    STATUS_UNENCRYPTED = 2'd2,
    STATUS_ACCEPTED    = 2'd3
  } status_t;

  localparam logic [7:0] AD_TYPE_SERVICE16 = 8'h16;
  localparam logic [7:0] UUID_FIRST        = 8'hD2;
  localparam logic [7:0] UUID_SECOND       = 8'hFC;
  localparam int unsigned ENCRYPTED_BIT    = 0;
  localparam logic [7:0] FIXED_OVERHEAD    = 8'd11;
  localparam logic [7:0] PAYLOAD_SKIP      = 8'd5;

  typedef struct packed {
    logic [7:0] adv_byte;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  dev_info;
    logic [7:0]  payload_offset;
    logic [7:0]  payload_len;
    logic [31:0] frame_counter;
    logic [31:0] mic;
  } out_beat_t;

endpackage

`default_nettype wire

[rtl/bthome_service_data_locator_unit.sv]
// Top level of the BTHome service-data locator: AD element walker and verdict register.
// Depends on bthome_pkg for the beat structs and verdict codes.
//
// Usage: the input channel carries one advertisement byte per beat, with last set on
// the final byte. Each beat is folded into the walker registers (position, current
// element, candidate flags and an eight-byte tail window) in the cycle it is taken.
// Only the final byte produces a result beat; it appears on the output channel in the
// cycle after that byte is accepted, and the walker returns to its reset state in the
// same cycle, so the first byte of the next advertisement may follow immediately.
// Throughput is one byte per cycle, set by the walker update, unless a final byte is held off.
// While a result waits under out_stall, further non-final bytes are still taken; a
// final byte is held off with in_stall until the output register is free.
// Reset (rst_n low, synchronous) clears the walker and drops out_valid.
// Bytes at index MAX_ADV_BYTES or above are not walked.
`timescale 1ns / 1ps
`default_nettype none

module bthome_service_data_locator_unit #(
  parameter int MAX_ADV_BYTES = 255
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire bthome_pkg::in_beat_t in_data,
  output logic                      out_valid,
  input  wire                       out_stall,
  output bthome_pkg::out_beat_t     out_data
);
  import bthome_pkg::*;

  localparam logic [7:0] MaxPos = 8'(MAX_ADV_BYTES);

  logic [7:0]  byte_pos_r,   byte_pos_nxt;
  logic [7:0]  elem_start_r, elem_start_nxt;
  logic [7:0]  elem_len_r,   elem_len_nxt;
  logic [7:0]  elem_type_r,  elem_type_nxt;
  logic        uuid_match_r, uuid_match_nxt;
  logic        stopped_r,    stopped_nxt;
  logic        found_r,      found_nxt;
  logic [7:0]  match_len_r,  match_len_nxt;
  logic [7:0]  dev_info_r,   dev_info_nxt;
  logic [63:0] tail_r,       tail_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_beat_t   out_data_r,  out_data_nxt;

  logic        in_acc;
  logic [7:0]  offs;
  logic [7:0]  b;

  assign b        = in_data.adv_byte;
  assign in_stall = out_valid_r && out_stall && in_data.last;
  assign in_acc   = in_valid && !in_stall;
  assign offs     = byte_pos_r - elem_start_r;

  // Walker update for one byte.
  always_comb begin
    elem_start_nxt = elem_start_r;
    elem_len_nxt   = elem_len_r;
    elem_type_nxt  = elem_type_r;
    uuid_match_nxt = uuid_match_r;
    stopped_nxt    = stopped_r;
    found_nxt      = found_r;
    match_len_nxt  = match_len_r;
    dev_info_nxt   = dev_info_r;
    tail_nxt       = tail_r;
    if (!stopped_r && !found_r) begin
      if (byte_pos_r >= MaxPos) begin
        stopped_nxt = 1'b1;
      end else if (byte_pos_r == elem_start_r) begin
        if (b == 8'd0) begin
          stopped_nxt = 1'b1;
        end else begin
          elem_len_nxt   = b;
          uuid_match_nxt = 1'b0;
          dev_info_nxt   = 8'd0;
        end
      end else begin
        // The type byte restarts the tail window for the new element.
        if (offs == 8'd1) begin
          elem_type_nxt = b;
          tail_nxt      = {b, 56'd0};
        end else begin
          tail_nxt = {b, tail_r[63:8]};
        end
        if (offs == 8'd2) begin
          uuid_match_nxt = (elem_type_r == AD_TYPE_SERVICE16) && (elem_len_r >= 8'd3) &&
                           (b == UUID_FIRST);
        end else if (offs == 8'd3) begin
          uuid_match_nxt = uuid_match_r && (b == UUID_SECOND);
        end else if (offs == 8'd4 && uuid_match_r) begin
          dev_info_nxt = b;
        end
        if (offs >= elem_len_r) begin
          if (uuid_match_nxt) begin
            found_nxt     = 1'b1;
            match_len_nxt = elem_len_r - 8'd1;
          end else begin
            elem_start_nxt = byte_pos_r + 8'd1;
          end
        end
      end
    end
  end

  assign byte_pos_nxt = (byte_pos_r == 8'hFF) ? byte_pos_r : byte_pos_r + 8'd1;

  // Verdict from the state as it stands after the final byte.
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt.status = STATUS_NONE;
    if (found_nxt) begin
      if (match_len_nxt < FIXED_OVERHEAD) begin
        out_data_nxt.status = STATUS_TOO_SHORT;
      end else if (!dev_info_nxt[ENCRYPTED_BIT]) begin
        out_data_nxt.status   = STATUS_UNENCRYPTED;
        out_data_nxt.dev_info = dev_info_nxt;
      end else if (match_len_nxt == FIXED_OVERHEAD) begin
        out_data_nxt.status = STATUS_TOO_SHORT;
      end else begin
        out_data_nxt.status         = STATUS_ACCEPTED;
        out_data_nxt.dev_info       = dev_info_nxt;
        out_data_nxt.payload_offset = elem_start_nxt + PAYLOAD_SKIP;
        out_data_nxt.payload_len    = match_len_nxt - FIXED_OVERHEAD;
        out_data_nxt.frame_counter  = tail_nxt[31:0];
        out_data_nxt.mic            = tail_nxt[63:32];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (in_acc && in_data.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r   <= '0;
      elem_start_r <= '0;
      elem_len_r   <= '0;
      elem_type_r  <= '0;
      uuid_match_r <= 1'b0;
      stopped_r    <= 1'b0;
      found_r      <= 1'b0;
      match_len_r  <= '0;
      dev_info_r   <= '0;
      tail_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        if (in_data.last) begin
          byte_pos_r   <= '0;
          elem_start_r <= '0;
          elem_len_r   <= '0;
          elem_type_r  <= '0;
          uuid_match_r <= 1'b0;
          stopped_r    <= 1'b0;
          found_r      <= 1'b0;
          match_len_r  <= '0;
          dev_info_r   <= '0;
          tail_r       <= '0;
        end else begin
          byte_pos_r   <= byte_pos_nxt;
          elem_start_r <= elem_start_nxt;
          elem_len_r   <= elem_len_nxt;
          elem_type_r  <= elem_type_nxt;
          uuid_match_r <= uuid_match_nxt;
          stopped_r    <= stopped_nxt;
          found_r      <= found_nxt;
          match_len_r  <= match_len_nxt;
          dev_info_r   <= dev_info_nxt;
          tail_r       <= tail_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.last) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/bthome_checker.sv]
// Port-level checks for the BTHome service-data locator, bound to its top level.
// Depends on bthome_pkg for the beat structs and verdict codes.
`timescale 1ns / 1ps
`default_nettype none

module bthome_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_stall,
  input wire bthome_pkg::in_beat_t  in_data,
  input wire                        out_valid,
  input wire                        out_stall,
  input wire bthome_pkg::out_beat_t out_data
);
  import bthome_pkg::*;

  // A stalled result stays up and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat dropped or changed");

  // A final byte taken always yields a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> out_valid)
    else $error("final byte gave no result beat");

  // A non-final byte never creates a result on its own.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.last && !(out_valid && out_stall) |=> !out_valid)
    else $error("result beat without a final byte");

  // A final byte must wait while the output register is occupied and stalled.
  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_data.last && out_valid && out_stall |-> in_stall)
    else $error("final byte taken while result register is blocked");

  // Only an accepted verdict carries payload details.
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_ACCEPTED |->
      out_data.payload_len == 8'd0 && out_data.frame_counter == 32'd0 &&
      out_data.mic == 32'd0)
    else $error("payload fields set on a non-accepted verdict");

endmodule

bind bthome_service_data_locator_unit bthome_checker u_bthome_checker (.*);

`default_nettype wire

[dv/tb_bthome_service_data_locator_unit.sv]
// Self-checking testbench for bthome_service_data_locator_unit.
// Builds advertisements byte by byte, predicts each verdict beat in place and checks it.
// Depends on bthome_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_bthome_service_data_locator_unit;
  import bthome_pkg::*;

  localparam int ADV_LIMIT = 255;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TOTAL_BYTES = 1200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;

  bthome_service_data_locator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  in_beat_t pending_beats[$];
  out_beat_t expected_verdicts[$];
  logic [7:0] adv[$];

  int mismatches = 0;
  int cycle_count = 0;
  int bytes_queued = 0;
  int adv_count = 0;
  int verdict_tally[4] = '{0, 0, 0, 0};

  // Element walker state of the predictor.
  logic [7:0] pos, el_start, el_len, el_type, svc_len, dev_info;
  logic uuid_ok, halted, found;
  logic [63:0] tail;

  task automatic clear_walker();
    pos = '0;
    el_start = '0;
    el_len = '0;
    el_type = '0;
    svc_len = '0;
    dev_info = '0;
    uuid_ok = 1'b0;
    halted = 1'b0;
    found = 1'b0;
    tail = '0;
  endtask

  task automatic advance_walker(input logic [7:0] b);
    logic [7:0] k;
    if (halted || found) return;
    if (int'(pos) >= ADV_LIMIT) begin
      halted = 1'b1;
      return;
    end
    if (pos == el_start) begin
      // A zero length byte ends the element list.
      if (b == 8'h00) begin
        halted = 1'b1;
        return;
      end
      el_len = b;
      uuid_ok = 1'b0;
      dev_info = '0;
      return;
    end
    k = pos - el_start;
    if (k == 8'd1) begin
      el_type = b;
      tail = '0;
    end else if (k == 8'd2) begin
      uuid_ok = (el_type == AD_TYPE_SERVICE16) && (el_len >= 8'd3) && (b == UUID_FIRST);
    end else if (k == 8'd3) begin
      uuid_ok = uuid_ok && (b == UUID_SECOND);
    end else if (k == 8'd4 && uuid_ok) begin
      dev_info = b;
    end
    tail = {b, tail[63:8]};
    if (k >= el_len) begin
      if (uuid_ok) begin
        found = 1'b1;
        svc_len = el_len - 8'd1;
      end else begin
        el_start = pos + 8'd1;
      end
    end
  endtask

  // Queues one beat and, on the final byte, the verdict it must produce.
  task automatic queue_byte(input logic [7:0] b, input logic last);
    out_beat_t v;
    in_beat_t beat;
    beat.adv_byte = b;
    beat.last = last;
    pending_beats.push_back(beat);
    bytes_queued++;
    advance_walker(b);
    if (!last) begin
      if (pos != 8'hFF) pos = pos + 8'd1;
      return;
    end
    v = '0;
    v.status = STATUS_NONE;
    if (found) begin
      if (svc_len < FIXED_OVERHEAD) begin
        v.status = STATUS_TOO_SHORT;
      end else if (!dev_info[ENCRYPTED_BIT]) begin
        v.status = STATUS_UNENCRYPTED;
        v.dev_info = dev_info;
      end else if (svc_len == FIXED_OVERHEAD) begin
        v.status = STATUS_TOO_SHORT;
      end else begin
        v.status = STATUS_ACCEPTED;
        v.dev_info = dev_info;
        v.payload_offset = el_start + PAYLOAD_SKIP;
        v.payload_len = svc_len - FIXED_OVERHEAD;
        v.frame_counter = tail[31:0];
        v.mic = tail[63:32];
      end
    end
    expected_verdicts.push_back(v);
    verdict_tally[v.status]++;
    clear_walker();
  endtask

  task automatic send_adv();
    foreach (adv[i]) queue_byte(adv[i], i == adv.size() - 1);
    adv.delete();
    adv_count++;
  endtask

  task automatic push_elem(input logic [7:0] ad_type, input int n);
    adv.push_back(8'(n + 1));
    adv.push_back(ad_type);
    repeat (n) adv.push_back(8'($urandom));
  endtask

  // Service-data element with the BTHome UUID; svc counts the bytes after the type.
  task automatic push_bthome(input int svc, input logic [7:0] dinfo);
    adv.push_back(8'(svc + 1));
    adv.push_back(AD_TYPE_SERVICE16);
    if (svc >= 1) adv.push_back(UUID_FIRST);
    if (svc >= 2) adv.push_back(UUID_SECOND);
    if (svc >= 3) adv.push_back(dinfo);
    for (int i = 3; i < svc; i++) adv.push_back(8'($urandom));
  endtask

  task automatic fill_tail(input logic [7:0] v);
    for (int i = 1; i <= 8; i++) adv[adv.size() - i] = v;
  endtask

  task automatic build_random_adv();
    int r, svc, s, cut;
    logic [7:0] dinfo;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 40)) adv.push_back(8'($urandom));
      return;
    end
    if ($urandom_range(0, 99) < 3) begin
      // Long filler so the candidate lands near or past the walk limit.
      repeat ($urandom_range(3, 5)) push_elem(8'hFF, $urandom_range(40, 62));
    end else begin
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 4) == 0) push_elem(AD_TYPE_SERVICE16, $urandom_range(2, 8));
        else push_elem(8'($urandom), $urandom_range(0, 10));
      end
    end
    if ($urandom_range(0, 99) < 5) adv.push_back(8'h00);
    r = $urandom_range(0, 99);
    if (r < 75) svc = $urandom_range(12, 30);
    else if (r < 92) svc = $urandom_range(0, 11);
    else svc = $urandom_range(31, 200);
    dinfo = 8'($urandom);
    if ($urandom_range(0, 3) != 0) dinfo[ENCRYPTED_BIT] = 1'b1;
    s = adv.size();
    push_bthome(svc, dinfo);
    if ($urandom_range(0, 99) < 10 && svc >= 2) begin
      // Break the type or one UUID byte by a single bit.
      adv[s + $urandom_range(1, 3)] ^= 8'(1 << $urandom_range(0, 7));
    end
    repeat ($urandom_range(0, 2)) push_elem(8'($urandom), $urandom_range(0, 12));
    if ($urandom_range(0, 99) < 10 && adv.size() > 1) begin
      cut = $urandom_range(1, (adv.size() - 1 < 12) ? adv.size() - 1 : 12);
      repeat (cut) void'(adv.pop_back());
    end
  endtask

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected %h, got %h (cycle %0d)", name, want, got, cycle_count);
  endtask

  task automatic check_verdict(input out_beat_t got);
    out_beat_t want;
    if (expected_verdicts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH: unexpected result beat %h (cycle %0d)", got, cycle_count);
      return;
    end
    want = expected_verdicts.pop_front();
    if (got.status !== want.status) report_field("status", want.status, got.status);
    if (got.dev_info !== want.dev_info)
      report_field("dev_info", want.dev_info, got.dev_info);
    if (got.payload_offset !== want.payload_offset)
      report_field("payload_offset", want.payload_offset, got.payload_offset);
    if (got.payload_len !== want.payload_len)
      report_field("payload_len", want.payload_len, got.payload_len);
    if (got.frame_counter !== want.frame_counter)
      report_field("frame_counter", want.frame_counter, got.frame_counter);
    if (got.mic !== want.mic) report_field("mic", want.mic, got.mic);
  endtask

  // Byte source: a new beat goes out only once the current one is taken.
  int src_gap = 0;
  int src_calm = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
        src_gap <= idle_len(src_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink with random back-pressure.
  int sink_hold = 0;
  int sink_calm = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      sink_hold <= 0;
    end else begin
      if (out_valid && !out_stall) check_verdict(out_data);
      if (sink_hold > 0) begin
        out_stall <= 1'b1;
        sink_hold <= sink_hold - 1;
      end else begin
        out_stall <= 1'b0;
        sink_hold <= idle_len(sink_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout with %0d result beats outstanding.", expected_verdicts.size());
      $display("tb_bthome_service_data_locator_unit: errors");
      $finish;
    end
  end

  initial begin
    int s;
    clear_walker();

    // Zero length at the start, and a lone length byte.
    adv.push_back(8'h00);
    send_adv();
    adv.push_back(8'hFF);
    send_adv();
    // Flags element, then an accepted frame that ends on the final byte.
    push_elem(8'h01, 1);
    push_bthome(20, 8'h41);
    send_adv();
    push_bthome(20, 8'h40);
    send_adv();
    // Empty payload, short service data, and the three-byte candidate.
    push_bthome(11, 8'h01);
    send_adv();
    push_bthome(10, 8'hFF);
    send_adv();
    push_bthome(2, 8'h00);
    send_adv();
    // Plain frame with the minimum service length still gives unencrypted.
    push_bthome(11, 8'h00);
    send_adv();
    push_bthome(12, 8'hFF);
    fill_tail(8'hFF);
    send_adv();
    push_bthome(12, 8'h01);
    fill_tail(8'h00);
    send_adv();
    // Wrong second UUID byte, swapped UUID, wrong type; the fourth element matches.
    push_bthome(16, 8'h01);
    adv[3] = 8'hFD;
    s = adv.size();
    push_bthome(14, 8'h01);
    adv[s + 2] = UUID_SECOND;
    adv[s + 3] = UUID_FIRST;
    s = adv.size();
    push_bthome(14, 8'h01);
    adv[s + 1] = 8'h17;
    push_bthome(16, 8'h03);
    send_adv();
    // Terminator before the candidate.
    push_elem(8'h09, 4);
    adv.push_back(8'h00);
    push_bthome(20, 8'h01);
    send_adv();
    // Candidate cut short by the final byte.
    push_bthome(20, 8'h01);
    void'(adv.pop_back());
    send_adv();
    // Final byte lands on a length byte.
    push_elem(8'h09, 3);
    adv.push_back(8'h15);
    send_adv();
    // Bytes after a match are ignored.
    push_bthome(13, 8'h01);
    push_elem(AD_TYPE_SERVICE16, 3);
    repeat (20) adv.push_back(8'($urandom));
    send_adv();
    // Only the first match counts.
    push_bthome(20, 8'hFE);
    push_bthome(20, 8'h01);
    send_adv();
    // Degenerate service elements ahead of a good one.
    push_bthome(0, 8'h00);
    push_bthome(1, 8'h00);
    push_bthome(24, 8'h01);
    send_adv();
    // Largest frame that still completes; its last byte is the last walked index.
    push_bthome(253, 8'hFF);
    send_adv();
    // Candidate that straddles the walk limit, with bytes running past the position limit.
    push_elem(8'h2A, 250);
    push_bthome(20, 8'h01);
    send_adv();

    while (bytes_queued < TOTAL_BYTES) begin
      build_random_adv();
      send_adv();
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_valid) @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d advertisements in %0d bytes over %0d cycles.",
             adv_count, bytes_queued, cycle_count);
    $display("Verdicts: %0d no match, %0d too short, %0d unencrypted, %0d accepted; %0d %s",
             verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
             mismatches, "mismatches.");
    if (mismatches == 0) begin
      $display("tb_bthome_service_data_locator_unit: clean");
    end else begin
      $display("tb_bthome_service_data_locator_unit: errors");
    end
    $finish;
  end

endmodule
